### sv/ps2kcr_pkg.sv
package ps2kcr_pkg;

	// Host commands and device responses
	localparam logic [7:0] RSP_ACK     = 8'hFA;
	localparam logic [7:0] RSP_BAT     = 8'hAA;
	localparam logic [7:0] CMD_ECHO    = 8'hEE;
	localparam logic [7:0] CMD_RESET   = 8'hFF;
	localparam logic [7:0] CMD_RESEND  = 8'hFE;
	localparam logic [7:0] CMD_ENABLE  = 8'hF4;
	localparam logic [7:0] CMD_DISABLE = 8'hF5;
	localparam logic [7:0] CMD_SETRATE = 8'hF3;
	localparam logic [7:0] CMD_READID  = 8'hF2;
	localparam logic [7:0] CMD_CODESET = 8'hF0;
	localparam logic [7:0] CMD_LEDS    = 8'hED;
	localparam logic [7:0] ID_BYTE0    = 8'hAB;
	localparam logic [7:0] ID_BYTE1    = 8'h83;
	localparam logic [7:0] LED_BITS    = 8'h07;
	localparam logic [7:0] SCAN_SET_RST = 8'd2;

	localparam int MAX_RSP = 3;

	typedef enum logic [1:0] {
		WAIT_NONE    = 2'd0,
		WAIT_LEDS    = 2'd1,
		WAIT_CODESET = 2'd2
	} pend_t;

	// Keyboard state carried between words
	typedef struct packed {
		pend_t      pend;
		logic [2:0] led;
		logic [7:0] scan;
	} state_t;

	// Responses produced by one host word
	typedef struct packed {
		logic [1:0]              cnt;
		logic [MAX_RSP-1:0][7:0] bytes;
		logic                    clr;
		logic [2:0]              led;
		logic [7:0]              scan;
	} rsp_t;

endpackage

### sv/ps2kcr_in_if.sv
interface ps2kcr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/ps2kcr_out_if.sv
interface ps2kcr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	logic       clear_buffers;
	logic [2:0] led_state;
	logic [7:0] code_set;

	modport source (output valid, output tx_byte, output last, output clear_buffers,
		output led_state, output code_set, input ready);
	modport sink (input valid, input tx_byte, input last, input clear_buffers,
		input led_state, input code_set, output ready);
endinterface

### sv/ps2kcr_decode.sv
module ps2kcr_decode (
	input  logic [7:0]          rx_byte,
	input  ps2kcr_pkg::state_t  cur,
	output ps2kcr_pkg::state_t  nxt,
	output ps2kcr_pkg::rsp_t    rsp
);

	always_comb begin
		nxt        = cur;
		nxt.pend   = ps2kcr_pkg::WAIT_NONE;
		rsp.cnt    = 2'd0;
		rsp.bytes  = '0;
		rsp.clr    = 1'b0;
		case (cur.pend)
			ps2kcr_pkg::WAIT_LEDS: begin
				nxt.led      = 3'(rx_byte & ps2kcr_pkg::LED_BITS);
				rsp.cnt      = 2'd1;
				rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
			end
			ps2kcr_pkg::WAIT_CODESET: begin
				// zero asks for the current set, anything else selects one
				if (rx_byte == 8'd0) begin
					rsp.cnt      = 2'd1;
					rsp.bytes[0] = cur.scan;
				end else begin
					nxt.scan = rx_byte;
				end
			end
			default: begin
				case (rx_byte)
					ps2kcr_pkg::RSP_ACK, ps2kcr_pkg::CMD_SETRATE,
					ps2kcr_pkg::CMD_RESEND: begin
						rsp.cnt = 2'd0;
					end
					ps2kcr_pkg::CMD_RESET: begin
						rsp.cnt      = 2'd2;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
						rsp.bytes[1] = ps2kcr_pkg::RSP_BAT;
					end
					ps2kcr_pkg::CMD_ENABLE, ps2kcr_pkg::CMD_DISABLE: begin
						rsp.cnt      = 2'd1;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
						rsp.clr      = 1'b1;
					end
					ps2kcr_pkg::CMD_ECHO: begin
						rsp.cnt      = 2'd1;
						rsp.bytes[0] = ps2kcr_pkg::CMD_ECHO;
					end
					ps2kcr_pkg::CMD_READID: begin
						rsp.cnt      = 2'd3;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
						rsp.bytes[1] = ps2kcr_pkg::ID_BYTE0;
						rsp.bytes[2] = ps2kcr_pkg::ID_BYTE1;
					end
					ps2kcr_pkg::CMD_LEDS: begin
						rsp.cnt      = 2'd1;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
						nxt.pend     = ps2kcr_pkg::WAIT_LEDS;
					end
					ps2kcr_pkg::CMD_CODESET: begin
						rsp.cnt      = 2'd1;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
						nxt.pend     = ps2kcr_pkg::WAIT_CODESET;
					end
					default: begin
						rsp.cnt      = 2'd1;
						rsp.bytes[0] = ps2kcr_pkg::RSP_ACK;
					end
				endcase
			end
		endcase
		rsp.led  = nxt.led;
		rsp.scan = nxt.scan;
	end

endmodule

### sv/ps2kcr_rsp_buf.sv
module ps2kcr_rsp_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ps2kcr_pkg::rsp_t    rsp,
	output logic                free,
	ps2kcr_out_if.source        tx
);

	logic [ps2kcr_pkg::MAX_RSP-1:0][7:0] byte_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       clr_q;
	logic [2:0] led_q;
	logic [7:0] scan_q;
	logic       at_last;

	assign at_last = (idx_q == cnt_q - 2'd1);
	assign free    = (cnt_q == 2'd0) || (tx.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= rsp.cnt;
			idx_q <= 2'd0;
		end else if (tx.valid && tx.ready) begin
			if (at_last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= rsp.bytes;
			clr_q  <= rsp.clr;
			led_q  <= rsp.led;
			scan_q <= rsp.scan;
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    tx.tx_byte = byte_q[0];
			2'd1:    tx.tx_byte = byte_q[1];
			2'd2:    tx.tx_byte = byte_q[2];
			default: tx.tx_byte = byte_q[0];
		endcase
	end

	assign tx.valid         = (cnt_q != 2'd0);
	assign tx.last          = at_last;
	assign tx.clear_buffers = clr_q && (idx_q == 2'd0);
	assign tx.led_state     = led_q;
	assign tx.code_set      = scan_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (idx_q < cnt_q))
		else $error("response index beyond count");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("response loaded over pending words");

	a_clr_single: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.clear_buffers) |-> tx.last)
		else $error("buffer clear on a multi-word response");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.ready && tx.last && !load) |=> !tx.valid)
		else $error("response valid after final word taken");

endmodule

### sv/ps2_keyboard_command_responder.sv
// PS/2 keyboard command responder, device side.
// rx (sink) carries one host word per handshake: a command, or the argument
// of a set-LEDs or set-code-set command that came just before it.
// tx (source) carries the response words: tx_byte, last on the final word of
// one host word, clear_buffers on the ACK of enable or disable, and the LED
// mask and scan code set as they stand after that host word.
// Path: a word accepted on rx waits in the input register, is decoded there
// combinationally, and its responses are loaded into the response buffer.
// Throughput: the response buffer sends one word per cycle while tx.ready is
// high; a host word with more than one response holds the decode stage until
// its final word is taken, so words with at most one response flow at one per
// cycle when tx does not stall. The response buffer is the limit: the next
// host word is decoded in the cycle that its final word is taken.
// Words with no response (ACK, set-rate, resend, a nonzero code set) only
// update state and never appear on tx.
// Reset: no argument awaited, LED mask 0, scan code set 2, both channels idle.
// When tx stalls, the buffer holds its word, one more host word waits in the
// input register, and rx.ready drops until the buffer frees.
module ps2_keyboard_command_responder (
	input  logic          clk,
	input  logic          arst_n,
	ps2kcr_in_if.sink     rx,
	ps2kcr_out_if.source  tx
);

	logic               rx_valid_s1;
	logic [7:0]         rx_byte_s1;
	ps2kcr_pkg::state_t state_q;
	ps2kcr_pkg::state_t state_nxt;
	ps2kcr_pkg::rsp_t   rsp;
	logic               buf_free;
	logic               load;

	// take a new word whenever the input register is empty or empties this cycle
	assign rx.ready = !rx_valid_s1 || buf_free;
	assign load     = rx_valid_s1 && buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			rx_valid_s1 <= 1'b1;
		end else if (load) begin
			rx_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// advance the keyboard state once per decoded host word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pend <= ps2kcr_pkg::WAIT_NONE;
			state_q.led  <= 3'd0;
			state_q.scan <= ps2kcr_pkg::SCAN_SET_RST;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	ps2kcr_decode u_decode (
		.rx_byte (rx_byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.rsp     (rsp)
	);

	ps2kcr_rsp_buf u_rsp_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.rsp    (rsp),
		.free   (buf_free),
		.tx     (tx)
	);

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One response word as it should appear on tx
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic       clear_buffers;
		logic [2:0] led_state;
		logic [7:0] code_set;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ps2kcr_in_if  rx_if ();
	ps2kcr_out_if tx_if ();

	ps2_keyboard_command_responder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.tx     (tx_if.source)
	);

	// Host words still to be offered; the head is the word on rx while valid is high
	logic [7:0] host_words[$];
	// Response words predicted but not yet seen on tx, oldest first
	reply_t replies_due[$];

	// Keyboard state as the predictor sees it
	ps2kcr_pkg::pend_t kb_pend;
	logic [2:0]        kb_led;
	logic [7:0]        kb_scan;

	int mismatches = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit word_taken = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the response words of one accepted host word and queue them.
	// Advance the keyboard state exactly as the block must.
	function automatic void predict_replies(input logic [7:0] b);
		logic [7:0] rb[3];
		logic       clr;
		logic [7:0] masked;
		int         n;
		reply_t     r;
		n = 0;
		clr = 1'b0;
		masked = b & ps2kcr_pkg::LED_BITS;
		case (kb_pend)
			ps2kcr_pkg::WAIT_LEDS: begin
				// Argument of set-LEDs: any byte, even a command code
				kb_pend = ps2kcr_pkg::WAIT_NONE;
				kb_led = masked[2:0];
				rb[0] = ps2kcr_pkg::RSP_ACK;
				n = 1;
			end
			ps2kcr_pkg::WAIT_CODESET: begin
				// Zero asks for the current set, anything else replaces it silently
				kb_pend = ps2kcr_pkg::WAIT_NONE;
				if (b == 8'h00) begin
					rb[0] = kb_scan;
					n = 1;
				end else begin
					kb_scan = b;
				end
			end
			default: begin
				// No argument awaited: decode as a command
				kb_pend = ps2kcr_pkg::WAIT_NONE;
				case (b)
					ps2kcr_pkg::RSP_ACK, ps2kcr_pkg::CMD_SETRATE,
					ps2kcr_pkg::CMD_RESEND: begin
					end
					ps2kcr_pkg::CMD_RESET: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						rb[1] = ps2kcr_pkg::RSP_BAT;
						n = 2;
					end
					ps2kcr_pkg::CMD_ENABLE, ps2kcr_pkg::CMD_DISABLE: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						clr = 1'b1;
						n = 1;
					end
					ps2kcr_pkg::CMD_ECHO: begin
						rb[0] = ps2kcr_pkg::CMD_ECHO;
						n = 1;
					end
					ps2kcr_pkg::CMD_READID: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						rb[1] = ps2kcr_pkg::ID_BYTE0;
						rb[2] = ps2kcr_pkg::ID_BYTE1;
						n = 3;
					end
					ps2kcr_pkg::CMD_LEDS: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						kb_pend = ps2kcr_pkg::WAIT_LEDS;
						n = 1;
					end
					ps2kcr_pkg::CMD_CODESET: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						kb_pend = ps2kcr_pkg::WAIT_CODESET;
						n = 1;
					end
					default: begin
						rb[0] = ps2kcr_pkg::RSP_ACK;
						n = 1;
					end
				endcase
			end
		endcase
		// LED mask and code set reflect the state after this word on every response
		for (int k = 0; k < n; k++) begin
			r.tx_byte = rb[k];
			r.last = (k == n - 1);
			r.clear_buffers = clr;
			r.led_state = kb_led;
			r.code_set = kb_scan;
			replies_due.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			if (mismatches < 40)
				$display("%0t ns: %s expected %02h, got %02h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Queue random host traffic: mostly well-formed commands and argument pairs,
	// the rest raw bytes that may break a pair or leave an argument pending.
	task automatic load_random(input int n_words);
		int added;
		int pick;
		added = 0;
		while (added < n_words) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				case ($urandom_range(7))
					0: host_words.push_back(ps2kcr_pkg::CMD_RESET);
					1: host_words.push_back(ps2kcr_pkg::CMD_ECHO);
					2: host_words.push_back(ps2kcr_pkg::CMD_READID);
					3: host_words.push_back(ps2kcr_pkg::CMD_ENABLE);
					4: host_words.push_back(ps2kcr_pkg::CMD_DISABLE);
					5: host_words.push_back(ps2kcr_pkg::CMD_RESEND);
					6: host_words.push_back(ps2kcr_pkg::CMD_SETRATE);
					default: host_words.push_back(ps2kcr_pkg::RSP_ACK);
				endcase
				added += 1;
			end else if (pick < 60) begin
				host_words.push_back(ps2kcr_pkg::CMD_LEDS);
				host_words.push_back(8'($urandom));
				added += 2;
			end else if (pick < 80) begin
				host_words.push_back(ps2kcr_pkg::CMD_CODESET);
				if ($urandom_range(99) < 35)
					host_words.push_back(8'h00);
				else
					host_words.push_back(8'($urandom));
				added += 2;
			end else begin
				host_words.push_back(8'($urandom));
				added += 1;
			end
		end
	endtask

	// Hold the sender until every queued word is taken and every response has
	// come back, then give a word with no response time to leave the decoder.
	task automatic drain_and_pause();
		while (host_words.size() != 0 || rx_if.valid)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Sender: change rx at the falling edge. Keep a word on rx until it is
	// taken, then either offer the next one or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'h00;
		end else if (!rx_if.valid || word_taken) begin
			word_taken = 1'b0;
			if (host_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				rx_if.valid <= 1'b1;
				rx_if.rx_byte <= host_words[0];
			end else begin
				rx_if.valid <= 1'b0;
				rx_if.rx_byte <= 8'($urandom);
			end
		end
	end

	// Receiver: change ready at the falling edge. A long hold-off, once asked
	// for, is counted down here; otherwise stall at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			tx_if.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 200;
			tx_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			tx_if.ready <= 1'b0;
		end else begin
			tx_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Monitor: sample both handshakes at the rising edge. Check each response
	// word against the oldest prediction; predict for each host word taken.
	always @(posedge clk) begin : monitor
		reply_t got;
		reply_t want;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			got.tx_byte = tx_if.tx_byte;
			got.last = tx_if.last;
			got.clear_buffers = tx_if.clear_buffers;
			got.led_state = tx_if.led_state;
			got.code_set = tx_if.code_set;
			if (replies_due.size() == 0) begin
				if (mismatches < 40)
					$display("%0t ns: unexpected word, expected none, got tx_byte %02h",
						$time, got.tx_byte);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("tx_byte", want.tx_byte, got.tx_byte);
				check_field("last", 8'(want.last), 8'(got.last));
				check_field("clear_buffers", 8'(want.clear_buffers), 8'(got.clear_buffers));
				check_field("led_state", 8'(want.led_state), 8'(got.led_state));
				check_field("code_set", want.code_set, got.code_set);
			end
		end
		if (arst_n && rx_if.valid && rx_if.ready) begin
			predict_replies(rx_if.rx_byte);
			void'(host_words.pop_front());
			word_taken = 1'b1;
		end
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		int settle;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		tx_if.ready = 1'b0;
		kb_pend = ps2kcr_pkg::WAIT_NONE;
		kb_led = 3'd0;
		kb_scan = ps2kcr_pkg::SCAN_SET_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed pass, no idling: every command, argument bytes that look
		// like commands, code-set query before and after a change, byte extremes
		host_words.push_back(8'h00);
		host_words.push_back(ps2kcr_pkg::CMD_RESET);
		host_words.push_back(ps2kcr_pkg::CMD_RESEND);
		host_words.push_back(ps2kcr_pkg::RSP_ACK);
		host_words.push_back(ps2kcr_pkg::CMD_SETRATE);
		host_words.push_back(ps2kcr_pkg::CMD_ECHO);
		host_words.push_back(ps2kcr_pkg::CMD_READID);
		host_words.push_back(ps2kcr_pkg::CMD_ENABLE);
		host_words.push_back(ps2kcr_pkg::CMD_DISABLE);
		host_words.push_back(ps2kcr_pkg::CMD_CODESET);
		host_words.push_back(8'h00);
		host_words.push_back(ps2kcr_pkg::CMD_LEDS);
		host_words.push_back(8'h05);
		host_words.push_back(ps2kcr_pkg::CMD_LEDS);
		host_words.push_back(ps2kcr_pkg::CMD_RESET);
		host_words.push_back(ps2kcr_pkg::CMD_CODESET);
		host_words.push_back(8'hFF);
		host_words.push_back(ps2kcr_pkg::CMD_CODESET);
		host_words.push_back(8'h00);
		host_words.push_back(ps2kcr_pkg::CMD_CODESET);
		host_words.push_back(ps2kcr_pkg::CMD_READID);
		host_words.push_back(ps2kcr_pkg::CMD_LEDS);
		host_words.push_back(8'hF8);
		host_words.push_back(8'h7F);
		host_words.push_back(8'h80);
		drain_and_pause();

		// No idling; hold tx off for a long stretch so the block backs up into rx
		hold_req = 1'b1;
		load_random(90);
		drain_and_pause();

		src_idle_pct = 48;
		load_random(90);
		drain_and_pause();

		src_idle_pct = 0;
		snk_stall_pct = 48;
		load_random(90);
		drain_and_pause();

		src_idle_pct = 27;
		snk_stall_pct = 27;
		load_random(90);

		// Drain: wait for the last responses, bounded, then let the block settle
		settle = 0;
		while ((host_words.size() != 0 || replies_due.size() != 0) && settle < 5000) begin
			@(posedge clk);
			settle++;
		end
		repeat (8) @(posedge clk);
		if (replies_due.size() != 0) begin
			$display("%0t ns: %0d expected words never arrived, next tx_byte %02h",
				$time, replies_due.size(), replies_due[0].tx_byte);
			mismatches++;
		end
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
